>>> src/psalu_pkg.sv
// ----------------------------------------------------------------------------
// psalu_pkg
// Shared types and codes for the packed SIMD integer ALU.
// ----------------------------------------------------------------------------
package psalu_pkg;

  // Operation codes
  typedef enum logic [2:0] {
    OP_ADD_SAT = 3'd0,
    OP_SUB_SAT = 3'd1,
    OP_MIN     = 3'd2,
    OP_MAX     = 3'd3,
    OP_ABS     = 3'd4,
    OP_AVGR    = 3'd5
  } op_e;

  // Lane size codes
  typedef enum logic [1:0] {
    LANE_8  = 2'd0,
    LANE_16 = 2'd1,
    LANE_32 = 2'd2
  } lane_size_e;

  localparam int unsigned VecWidth  = 128;
  localparam int unsigned HalfWidth = 64;

  // Input transaction
  typedef struct packed {
    logic [2:0]           operation;
    logic [1:0]           lane_size;
    logic                 signedness;
    logic [HalfWidth-1:0] left_low;
    logic [HalfWidth-1:0] left_high;
    logic [HalfWidth-1:0] right_low;
    logic [HalfWidth-1:0] right_high;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [HalfWidth-1:0] result_low;
    logic [HalfWidth-1:0] result_high;
    logic                 unsupported;
  } out_t;

endpackage

>>> src/psalu_lane.sv
// ----------------------------------------------------------------------------
// psalu_lane
// One lane of width W: saturating add/sub, min/max, abs, rounding average.
// ----------------------------------------------------------------------------
module psalu_lane #(
  parameter int unsigned W = 8
) (
  input  logic [2:0]   op_i,
  input  logic         sgn_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic [W-1:0] res_o
);

  logic [W:0]   sum;
  logic [W:0]   diff;
  logic [W:0]   avg_sum;
  logic         add_ovf;
  logic         sub_ovf;
  logic         lt;
  logic         gt;
  logic [W-1:0] smax;
  logic [W-1:0] smin;

  assign sum     = {1'b0, a_i} + {1'b0, b_i};
  assign diff    = {1'b0, a_i} - {1'b0, b_i};
  assign avg_sum = sum + {{W{1'b0}}, 1'b1};

  // Signed overflow: result sign differs from the left operand's where it should not
  assign add_ovf = (a_i[W-1] == b_i[W-1]) && (sum[W-1] != a_i[W-1]);
  assign sub_ovf = (a_i[W-1] != b_i[W-1]) && (diff[W-1] != a_i[W-1]);

  assign lt = sgn_i ? ($signed(a_i) < $signed(b_i)) : (a_i < b_i);
  assign gt = sgn_i ? ($signed(a_i) > $signed(b_i)) : (a_i > b_i);

  assign smax = {1'b0, {(W-1){1'b1}}};
  assign smin = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    res_o = '0;
    case (psalu_pkg::op_e'(op_i))
      psalu_pkg::OP_ADD_SAT: begin
        if (sgn_i) begin
          res_o = add_ovf ? (a_i[W-1] ? smin : smax) : sum[W-1:0];
        end else begin
          res_o = sum[W] ? {W{1'b1}} : sum[W-1:0];
        end
      end
      psalu_pkg::OP_SUB_SAT: begin
        if (sgn_i) begin
          res_o = sub_ovf ? (a_i[W-1] ? smin : smax) : diff[W-1:0];
        end else begin
          res_o = diff[W] ? '0 : diff[W-1:0];
        end
      end
      psalu_pkg::OP_MIN: res_o = lt ? a_i : b_i;
      psalu_pkg::OP_MAX: res_o = gt ? a_i : b_i;
      psalu_pkg::OP_ABS: res_o = a_i[W-1] ? (~a_i + {{(W-1){1'b0}}, 1'b1}) : a_i;
      psalu_pkg::OP_AVGR: res_o = avg_sum[W:1];
      default: res_o = '0;
    endcase
  end

endmodule

>>> src/psalu_vec.sv
// ----------------------------------------------------------------------------
// psalu_vec
// Full-width datapath: lane arrays for 8/16/32-bit lanes and lane-size select.
// ----------------------------------------------------------------------------
module psalu_vec (
  input  logic [2:0]                       op_i,
  input  logic [1:0]                       lane_size_i,
  input  logic                             sgn_i,
  input  logic [psalu_pkg::VecWidth-1:0]   left_i,
  input  logic [psalu_pkg::VecWidth-1:0]   right_i,
  output logic [psalu_pkg::VecWidth-1:0]   res_o
);

  localparam int unsigned N8  = psalu_pkg::VecWidth / 8;
  localparam int unsigned N16 = psalu_pkg::VecWidth / 16;
  localparam int unsigned N32 = psalu_pkg::VecWidth / 32;

  logic [psalu_pkg::VecWidth-1:0] res8;
  logic [psalu_pkg::VecWidth-1:0] res16;
  logic [psalu_pkg::VecWidth-1:0] res32;

  for (genvar i = 0; i < N8; i++) begin : g_l8
    psalu_lane #(.W(8)) u_lane (
      .op_i  (op_i),
      .sgn_i (sgn_i),
      .a_i   (left_i[i*8 +: 8]),
      .b_i   (right_i[i*8 +: 8]),
      .res_o (res8[i*8 +: 8])
    );
  end

  for (genvar i = 0; i < N16; i++) begin : g_l16
    psalu_lane #(.W(16)) u_lane (
      .op_i  (op_i),
      .sgn_i (sgn_i),
      .a_i   (left_i[i*16 +: 16]),
      .b_i   (right_i[i*16 +: 16]),
      .res_o (res16[i*16 +: 16])
    );
  end

  for (genvar i = 0; i < N32; i++) begin : g_l32
    psalu_lane #(.W(32)) u_lane (
      .op_i  (op_i),
      .sgn_i (sgn_i),
      .a_i   (left_i[i*32 +: 32]),
      .b_i   (right_i[i*32 +: 32]),
      .res_o (res32[i*32 +: 32])
    );
  end

  always_comb begin
    case (psalu_pkg::lane_size_e'(lane_size_i))
      psalu_pkg::LANE_8:  res_o = res8;
      psalu_pkg::LANE_16: res_o = res16;
      psalu_pkg::LANE_32: res_o = res32;
      default:            res_o = '0;
    endcase
  end

endmodule

>>> src/packed_simd_integer_alu.sv
// ----------------------------------------------------------------------------
// packed_simd_integer_alu
// 128-bit packed integer SIMD ALU: saturating add/sub, min/max, abs, avgr.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+------------------------
//  in      | input     | in_valid_i / in_stall_o | in_data_i  (in_t)
//  out     | output    | out_valid_o/ out_stall_i| out_data_o (out_t)
//
//  A transaction passes through two registers: the input register, then the
//  result register. One transaction is accepted per cycle while the output
//  does not stall; that holds because each register can hand its contents
//  on and take new ones at the same edge. The lane arrays between the two
//  registers are purely combinational. Reset clears both valid flags;
//  payload registers are not reset. A stall on the output holds the result;
//  the input register takes a transaction while empty or able to move on.
// ----------------------------------------------------------------------------
module packed_simd_integer_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  psalu_pkg::in_t      in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psalu_pkg::out_t     out_data_o
);

  // Input register
  psalu_pkg::in_t  in_q;
  logic            in_valid_q;
  logic            in_valid_d;

  // Result register
  psalu_pkg::out_t out_q;
  psalu_pkg::out_t out_d;
  logic            out_valid_q;
  logic            out_valid_d;

  logic            in_take;   // transaction accepted on the input
  logic            adv;       // input register moves into the result register
  logic            supported;
  logic [psalu_pkg::VecWidth-1:0] vec_res;

  // Input register full and result register free or being emptied this cycle
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take || (in_valid_q && !adv);
  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  // Pairings and codes the unit does not implement
  always_comb begin
    supported = 1'b1;
    if (in_q.lane_size > psalu_pkg::LANE_32 || in_q.operation > psalu_pkg::OP_AVGR) begin
      supported = 1'b0;
    end else if (in_q.lane_size == psalu_pkg::LANE_32 &&
                 (in_q.operation == psalu_pkg::OP_ADD_SAT ||
                  in_q.operation == psalu_pkg::OP_SUB_SAT ||
                  in_q.operation == psalu_pkg::OP_AVGR)) begin
      supported = 1'b0;
    end
  end

  psalu_vec u_vec (
    .op_i        (in_q.operation),
    .lane_size_i (in_q.lane_size),
    .sgn_i       (in_q.signedness),
    .left_i      ({in_q.left_high, in_q.left_low}),
    .right_i     ({in_q.right_high, in_q.right_low}),
    .res_o       (vec_res)
  );

  always_comb begin
    out_d.unsupported = !supported;
    out_d.result_low  = supported ? vec_res[psalu_pkg::HalfWidth-1:0] : '0;
    out_d.result_high = supported ?
                        vec_res[psalu_pkg::VecWidth-1:psalu_pkg::HalfWidth] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // An unsupported result carries an all-zero vector
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.unsupported |-> out_q.result_low == '0 && out_q.result_high == '0)
    else $error("unsupported result with non-zero data");

  // The input side only stalls while it holds a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled while input register empty");

  // An accepted transaction lands in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_valid_q)
    else $error("accepted transaction lost");

  // A transaction leaving the input register shows up as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("transaction lost between registers");
`endif

endmodule
